### hdl/word_symbol_tokenizer_unit_macros.svh
// Assertion shorthands for the tokenizer checker.
// Each expects clk and rst_n in scope.
`ifndef WORD_SYMBOL_TOKENIZER_UNIT_MACROS_SVH
`define WORD_SYMBOL_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication.
`define WST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/wst_pkg.sv
package wst_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_SYMBOLS_DEF   = 8;
    localparam int SYMBOL_BYTES_DEF  = 8;
    localparam int LENGTH_BITS_DEF   = 16;
    localparam int POSITION_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Fixed field widths
    localparam int CHAR_BITS         = 8;
    localparam int TOKEN_START_BITS  = 32;
    localparam int TOKEN_LENGTH_BITS = 16;
    localparam int CFG_INDEX_BITS    = 3;
    localparam int CFG_DATA_BITS     = 64;
    localparam int OUT_DATA_BITS     = TOKEN_START_BITS + TOKEN_LENGTH_BITS;
    localparam int OUT_USER_BITS     = 2;

    // Token kind codes
    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_SYMBOL = 1'b1;

    // Character classes
    typedef enum logic [1:0] {
        CLS_SPACE,
        CLS_WORD,
        CLS_SYMBOL
    } char_class_t;

    // One classified word in the queue
    typedef struct packed {
        logic [CHAR_BITS-1:0] chr;
        logic                 eos;
        char_class_t          cls;
    } wst_item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic      valid;
        wst_item_t item;
    } wst_head_t;

    // One result word
    typedef struct packed {
        logic [TOKEN_START_BITS-1:0]  start;
        logic [TOKEN_LENGTH_BITS-1:0] length;
        logic                         kind;
        logic                         unknown;
    } wst_result_t;

    // Whitespace: NUL, tab..CR, space. Word: 0-9, A-Z, a-z.
    function automatic char_class_t classify(input logic [CHAR_BITS-1:0] c);
        char_class_t cls;
        if (c inside {8'd0, 8'd32, [8'd9:8'd13]})
        begin
            cls = CLS_SPACE;
        end
        else if (c inside {[8'd48:8'd57], [8'd65:8'd90], [8'd97:8'd122]})
        begin
            cls = CLS_WORD;
        end
        else
        begin
            cls = CLS_SYMBOL;
        end
        return cls;
    endfunction

endpackage

### hdl/wst_front.sv
// Front end: accepts characters, classifies them and queues them.
module wst_front import wst_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CHAR_BITS-1:0] s_tdata,   // [7:0] character
    input  logic                 s_tlast,
    output wst_head_t            head,
    input  logic                 pop
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    wst_item_t             mem [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  push;
    logic                  do_pop;

    assign s_tready = (count_reg != CNT_BITS'(DEPTH));
    assign push     = s_tvalid && s_tready;
    assign do_pop   = pop && (count_reg != '0);

    // Head of queue
    assign head.valid = (count_reg != '0);
    assign head.item  = mem[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, classified on the way in
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= '{chr: s_tdata, eos: s_tlast, cls: classify(s_tdata)};
        end
    end

endmodule

### hdl/wst_back.sv
// Back end: tokenizer state, symbol table match and output register.
module wst_back import wst_pkg::*; #(
    parameter int NUM_SYMBOLS   = NUM_SYMBOLS_DEF,
    parameter int SYMBOL_BYTES  = SYMBOL_BYTES_DEF,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  wst_head_t                 head,
    output logic                      pop,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DATA_BITS-1:0]  m_tdata,
    output logic [OUT_USER_BITS-1:0]  m_tuser,
    output logic                      m_tlast
);

    localparam int TW = 8 * SYMBOL_BYTES;
    localparam int LW = (LENGTH_BITS < TOKEN_LENGTH_BITS) ? LENGTH_BITS : TOKEN_LENGTH_BITS;
    localparam int PW = POSITION_BITS;
    localparam logic [LW-1:0] LEN_CAP = {LW{1'b1}};

    // Symbol table
    logic [TW-1:0] tab_reg [NUM_SYMBOLS];

    // Tokenizer state
    logic          iwc_reg,    iwc_next;
    logic [TW-1:0] ptext_reg,  ptext_next;
    logic [LW-1:0] plen_reg,   plen_next;
    logic [PW-1:0] pstart_reg, pstart_next;
    logic [PW-1:0] pos_reg,    pos_next;
    logic          err_reg,    err_next;

    // Output stage
    logic          second_reg;
    logic          m_tvalid_reg;
    wst_result_t   out_reg;
    logic          m_tlast_reg;

    logic [CHAR_BITS-1:0] chr;
    logic [TW-1:0]        ext_text;
    logic [TW-1:0]        chr_text;
    logic [NUM_SYMBOLS-1:0] hit_p, hit_t, hit_c;
    logic known_p, known_t, known_c;
    logic can_ext;
    logic do_close, do_start, do_flip;
    logic e0, e1, bad0, ok;
    wst_result_t res_a, res_b, res_first;
    logic two, any, out_free, commit, load;

    assign chr      = head.item.chr;
    assign chr_text = TW'(chr);

    // Candidate text: pending symbol with the character appended
    for (genvar k = 0; k < SYMBOL_BYTES; k++)
    begin : g_ext
        assign ext_text[8*k +: 8] = (plen_reg == LW'(k)) ? chr : ptext_reg[8*k +: 8];
    end

    // Table writes and the three compare banks
    for (genvar i = 0; i < NUM_SYMBOLS; i++)
    begin : g_tab
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tab_reg[i] <= '0;
            end
            else if (cfg_we && (cfg_index == CFG_INDEX_BITS'(i)))
            begin
                tab_reg[i] <= cfg_data[TW-1:0];
            end
        end
        assign hit_p[i] = (tab_reg[i] != '0) && (tab_reg[i] == ptext_reg);
        assign hit_t[i] = (tab_reg[i] != '0) && (tab_reg[i] == ext_text);
        assign hit_c[i] = (tab_reg[i] != '0) && (tab_reg[i] == chr_text);
    end

    assign known_p = |hit_p;
    assign known_t = |hit_t;
    assign known_c = |hit_c;
    assign can_ext = (plen_reg < LW'(SYMBOL_BYTES)) && known_t;

    // Next tokenizer state and the results of the head word
    always_comb
    begin
        iwc_next    = iwc_reg;
        ptext_next  = ptext_reg;
        plen_next   = plen_reg;
        pstart_next = pstart_reg;
        pos_next    = pos_reg;
        err_next    = err_reg;
        do_close    = 1'b0;
        do_start    = 1'b0;
        do_flip     = 1'b0;

        if (!err_reg)
        begin
            case (head.item.cls)
                CLS_SPACE:
                begin
                    do_close = 1'b1;
                end
                default:
                begin
                    if ((head.item.cls == CLS_WORD) == iwc_reg)
                    begin
                        if (plen_reg == '0)
                        begin
                            do_start = 1'b1;
                        end
                        else if (iwc_reg)
                        begin
                            if (plen_reg != LEN_CAP)
                            begin
                                plen_next = plen_reg + 1'b1;
                            end
                        end
                        else if (can_ext)
                        begin
                            ptext_next = ext_text;
                            plen_next  = plen_reg + 1'b1;
                        end
                        else
                        begin
                            do_close = 1'b1;
                            do_start = 1'b1;
                        end
                    end
                    else
                    begin
                        do_close = 1'b1;
                        do_flip  = 1'b1;
                        do_start = 1'b1;
                    end
                end
            endcase
        end

        // Close the old pending token
        e0   = do_close && (plen_reg != '0);
        bad0 = e0 && !iwc_reg && !known_p;
        ok   = !bad0;
        res_a.start   = TOKEN_START_BITS'(pstart_reg);
        res_a.length  = TOKEN_LENGTH_BITS'(plen_reg);
        res_a.kind    = iwc_reg ? KIND_WORD : KIND_SYMBOL;
        res_a.unknown = bad0;
        if (do_close)
        begin
            ptext_next = '0;
            plen_next  = '0;
        end
        if (bad0)
        begin
            err_next = 1'b1;
        end
        if (ok && do_flip)
        begin
            iwc_next = !iwc_reg;
        end
        if (ok && do_start)
        begin
            pstart_next = pos_reg;
            plen_next   = LW'(1);
            ptext_next  = iwc_next ? '0 : chr_text;
        end

        // End of string flushes the new pending token
        e1 = !err_reg && ok && head.item.eos && (plen_next != '0);
        res_b.start   = TOKEN_START_BITS'(pstart_next);
        res_b.length  = TOKEN_LENGTH_BITS'(plen_next);
        res_b.kind    = iwc_next ? KIND_WORD : KIND_SYMBOL;
        res_b.unknown = !iwc_next && !((ok && do_start) ? known_c : 1'b1);

        if (head.item.eos)
        begin
            iwc_next    = 1'b1;
            ptext_next  = '0;
            plen_next   = '0;
            pstart_next = '0;
            pos_next    = '0;
            err_next    = 1'b0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // Result sequencing: up to two words per head item
    assign two       = e0 && e1;
    assign any       = e0 || e1;
    assign res_first = e0 ? res_a : res_b;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign load      = head.valid && any && out_free;
    assign commit    = head.valid && (!any || (out_free && (second_reg || !two)));
    assign pop       = commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iwc_reg      <= 1'b1;
            ptext_reg    <= '0;
            plen_reg     <= '0;
            pstart_reg   <= '0;
            pos_reg      <= '0;
            err_reg      <= 1'b0;
            second_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                iwc_reg    <= iwc_next;
                ptext_reg  <= ptext_next;
                plen_reg   <= plen_next;
                pstart_reg <= pstart_next;
                pos_reg    <= pos_next;
                err_reg    <= err_next;
                second_reg <= 1'b0;
            end
            else if (load)
            begin
                second_reg <= 1'b1;
            end
            if (load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg     <= second_reg ? res_b : res_first;
            m_tlast_reg <= second_reg || !two;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.length, out_reg.start};
    assign m_tuser  = {out_reg.unknown, out_reg.kind};
    assign m_tlast  = m_tlast_reg;

endmodule

### hdl/word_symbol_tokenizer_unit.sv
// Word and symbol tokenizer.
// Input stream: one character per word on s_tdata[7:0]; s_tlast marks the
// last character of a string. Output stream: one token per word with start
// offset and length on m_tdata, kind and unknown-symbol flag on m_tuser,
// m_tlast on the final token caused by one input character.
// Symbol table: eight 64-bit entries written through cfg_we/cfg_index/
// cfg_data, byte 0 holding the first character, zero meaning unused.
// With an empty queue and a free output register, a token reaches m_tdata
// when the output register loads it, after the character that closes it
// is written into the queue at the accepting edge. Throughput: one
// character per cycle while m_tready is high. A character that closes two
// tokens holds the back end until its second token is loaded; the
// four-entry queue absorbs this. The back end's single tokenizer state
// update per cycle sets the rate. Reset empties the queue, clears the
// tokenizer state and zeroes the table, so no symbol is known until
// written. When m_tready is low the output register holds its token, the
// back end stalls on its next token, and s_tready drops once the queue is full.
module word_symbol_tokenizer_unit import wst_pkg::*; #(
    parameter int NUM_SYMBOLS   = NUM_SYMBOLS_DEF,
    parameter int SYMBOL_BYTES  = SYMBOL_BYTES_DEF,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [CHAR_BITS-1:0]      s_tdata,   // [7:0] character
    input  logic                      s_tlast,   // end_of_string
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DATA_BITS-1:0]  m_tdata,   // [31:0] token_start, [47:32] token_length
    output logic [OUT_USER_BITS-1:0]  m_tuser,   // [0] token_kind, [1] unknown_symbol
    output logic                      m_tlast,   // last_of_run
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    wst_head_t head;
    logic      pop;

    wst_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .head     (head),
        .pop      (pop)
    );

    wst_back #(
        .NUM_SYMBOLS   (NUM_SYMBOLS),
        .SYMBOL_BYTES  (SYMBOL_BYTES),
        .LENGTH_BITS   (LENGTH_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### hdl/wst_checker.sv
`include "word_symbol_tokenizer_unit_macros.svh"

// Port-level checks on the tokenizer output stream.
module wst_checker import wst_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [OUT_DATA_BITS-1:0] m_tdata,
    input logic [OUT_USER_BITS-1:0] m_tuser,
    input logic                     m_tlast
);

    logic [TOKEN_LENGTH_BITS-1:0] tok_len;
    logic                         tok_kind;
    logic                         tok_unknown;

    assign tok_len     = m_tdata[OUT_DATA_BITS-1:TOKEN_START_BITS];
    assign tok_kind    = m_tuser[0];
    assign tok_unknown = m_tuser[1];

    // Stalled token stays offered
    `WST_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "token dropped while stalled")
    // Every token covers at least one character
    `WST_ASSERT_SAME(a_len_nonzero, m_tvalid, tok_len != '0, "token of zero length")
    // Only symbols can be unknown
    `WST_ASSERT_SAME(a_unknown_kind, m_tvalid && tok_unknown, tok_kind == KIND_SYMBOL, "unknown word")
    // An error ends the results of its character
    `WST_ASSERT_SAME(a_unknown_last, m_tvalid && tok_unknown, m_tlast, "result after error")

endmodule

bind word_symbol_tokenizer_unit wst_checker u_wst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
